/* rtl/core/pbh_pkg.sv */
// shared types and constants for the binary hash window filter
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package pbh_pkg;

  localparam int PIX_W  = 8;
  localparam int COEF_W = 16;
  localparam int IDX_W  = 7;
  localparam int POS_W  = 7;
  localparam int CODE_W = 4;
  localparam int DIM_W  = 11;
  localparam int CFG_W  = 8;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam int MAX_HEIGHT = 128;

  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_COEF  = 1'b1;

  localparam logic [PADDR_W-1:0] REG_WIDTH_ADDR  = 3'd0;
  localparam logic [PADDR_W-1:0] REG_HEIGHT_ADDR = 3'd4;

  typedef struct packed {
    logic                     command;
    logic [PIX_W-1:0]         pixel;
    logic [IDX_W-1:0]         coef_index;
    logic signed [COEF_W-1:0] coef_value;
  } in_word_t;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [POS_W-1:0]  out_row;
    logic [POS_W-1:0]  out_col;
    logic              last_of_frame;
  } out_word_t;

  typedef struct packed {
    logic [POS_W-1:0] out_row;
    logic [POS_W-1:0] out_col;
    logic             last_of_frame;
  } tag_t;

endpackage
`default_nettype wire

/* rtl/core/pcanet_binary_hash_5x5_core.sv */
// top level: register port, raster counters, stage control and output register
// depends on pbh_pkg, pbh_window, pbh_filter
`timescale 1ns / 1ps
`default_nettype none
// Takes one word per clock, pixels and coefficient loads alike, and returns one
// code word for every pixel that completes a full window. The line memory holds
// one word per column with one byte per stored row; it is read when a pixel is
// taken and written back with the new pixel from the stage 1 registers once the
// pipeline advances, so its single read and write ports set the rate of one word
// per cycle. While a code word in the output register is stalled the whole
// pipeline holds and the input stalls with it; otherwise the input never stalls.
// No clearing pass follows reset. Writing either size register restarts the frame.
module pcanet_binary_hash_5x5_core #(
  parameter int MAX_WIDTH   = 128,
  parameter int WINDOW      = 5,
  parameter int NUM_FILTERS = 4
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire pbh_pkg::in_word_t              in_word_i,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output pbh_pkg::out_word_t                  out_word_o,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [pbh_pkg::PADDR_W-1:0]    paddr,
  input  wire logic [pbh_pkg::PDATA_W-1:0]    pwdata,
  output logic [pbh_pkg::PDATA_W-1:0]         prdata,
  output logic                                pready
);
  import pbh_pkg::*;

  localparam int LINES  = WINDOW - 1;
  localparam int SLOT_W = $clog2(LINES);
  localparam int COL_W  = $clog2(MAX_WIDTH);

  logic [CFG_W-1:0] width_q, height_q;
  logic             cfg_wr;

  logic [COL_W-1:0]  col_q;
  logic [POS_W-1:0]  row_q;
  logic [SLOT_W-1:0] slot_q;

  logic [DIM_W-1:0] w_eff, w_raw;
  logic [CFG_W-1:0] h_eff;
  logic             adv, take, take_pix;
  logic             col_wrap, row_wrap, emit, last;

  logic              v1_pix_q, v1_cmd_q, emit1_q;
  logic [COL_W-1:0]  col1_q;
  logic [SLOT_W-1:0] slot1_q;
  logic [PIX_W-1:0]  pix1_q;
  logic [IDX_W-1:0]  idx1_q;
  logic signed [COEF_W-1:0] val1_q;
  tag_t              tag1_q, tag2_q, tag_d, ftag;
  logic              v2_q;

  logic [WINDOW*WINDOW*PIX_W-1:0] win;
  logic                           fvalid;
  logic [CODE_W-1:0]              fcode;

  logic      out_valid_q;
  out_word_t out_word_q;

  // register port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= CFG_W'(80);
      height_q <= CFG_W'(80);
    end else if (cfg_wr) begin
      if (paddr == REG_WIDTH_ADDR) begin
        width_q <= pwdata[CFG_W-1:0];
      end else if (paddr == REG_HEIGHT_ADDR) begin
        height_q <= pwdata[CFG_W-1:0];
      end
    end
  end

  always_comb begin
    case (paddr)
      REG_WIDTH_ADDR:  prdata = PDATA_W'(width_q);
      REG_HEIGHT_ADDR: prdata = PDATA_W'(height_q);
      default:         prdata = '0;
    endcase
  end

  // effective image size
  assign w_raw = DIM_W'(width_q);
  always_comb begin
    if (w_raw < DIM_W'(WINDOW)) begin
      w_eff = DIM_W'(WINDOW);
    end else if (w_raw > DIM_W'(MAX_WIDTH)) begin
      w_eff = DIM_W'(MAX_WIDTH);
    end else begin
      w_eff = w_raw;
    end
    if (height_q < CFG_W'(WINDOW)) begin
      h_eff = CFG_W'(WINDOW);
    end else if (height_q > CFG_W'(MAX_HEIGHT)) begin
      h_eff = CFG_W'(MAX_HEIGHT);
    end else begin
      h_eff = height_q;
    end
  end

  // handshake
  assign adv        = !out_valid_q || !out_stall_i;
  assign in_stall_o = !adv;
  assign take       = in_valid_i && adv;
  assign take_pix   = take && (in_word_i.command == CMD_PIXEL);

  // raster position
  assign col_wrap = (DIM_W'(col_q) + DIM_W'(1)) >= w_eff;
  assign row_wrap = (CFG_W'(row_q) + CFG_W'(1)) >= h_eff;
  assign emit     = (row_q >= POS_W'(LINES)) && (col_q >= COL_W'(LINES));
  assign last     = (CFG_W'(row_q) == h_eff - CFG_W'(1)) &&
                    (DIM_W'(col_q) == w_eff - DIM_W'(1));

  always_comb begin
    tag_d.out_row       = row_q - POS_W'(LINES);
    tag_d.out_col       = POS_W'(col_q - COL_W'(LINES));
    tag_d.last_of_frame = last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      slot_q <= '0;
    end else if (cfg_wr && ((paddr == REG_WIDTH_ADDR) || (paddr == REG_HEIGHT_ADDR))) begin
      col_q  <= '0;
      row_q  <= '0;
      slot_q <= '0;
    end else if (take_pix) begin
      if (col_wrap) begin
        col_q <= '0;
        if (row_wrap) begin
          row_q  <= '0;
          slot_q <= '0;
        end else begin
          row_q  <= row_q + POS_W'(1);
          slot_q <= (slot_q == SLOT_W'(LINES - 1)) ? '0 : slot_q + SLOT_W'(1);
        end
      end else begin
        col_q <= col_q + COL_W'(1);
      end
    end
  end

  // stage 1 and 2 control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_pix_q <= 1'b0;
      v1_cmd_q <= 1'b0;
      v2_q     <= 1'b0;
    end else if (adv) begin
      v1_pix_q <= take_pix;
      v1_cmd_q <= take && (in_word_i.command == CMD_COEF);
      v2_q     <= v1_pix_q && emit1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      col1_q  <= col_q;
      slot1_q <= slot_q;
      pix1_q  <= in_word_i.pixel;
      idx1_q  <= in_word_i.coef_index;
      val1_q  <= in_word_i.coef_value;
      emit1_q <= emit;
      tag1_q  <= tag_d;
      tag2_q  <= tag1_q;
    end
  end

  pbh_window #(
    .MAX_WIDTH (MAX_WIDTH),
    .WINDOW    (WINDOW)
  ) u_window (
    .clk_i     (clk_i),
    .rd_en_i   (take_pix),
    .rd_addr_i (col_q),
    .wr_en_i   (adv && v1_pix_q),
    .wr_addr_i (col1_q),
    .wr_slot_i (slot1_q),
    .wr_pix_i  (pix1_q),
    .win_o     (win)
  );

  pbh_filter #(
    .WINDOW      (WINDOW),
    .NUM_FILTERS (NUM_FILTERS)
  ) u_filter (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .cwe_i   (adv && v1_cmd_q),
    .cidx_i  (idx1_q),
    .cval_i  (val1_q),
    .valid_i (v2_q),
    .tag_i   (tag2_q),
    .win_i   (win),
    .valid_o (fvalid),
    .tag_o   (ftag),
    .code_o  (fcode)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= fvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_word_q.code          <= fcode;
      out_word_q.out_row       <= ftag.out_row;
      out_word_q.out_col       <= ftag.out_col;
      out_word_q.last_of_frame <= ftag.last_of_frame;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule
`default_nettype wire

/* rtl/core/pbh_window.sv */
// line memory (one word per column, one byte per stored line) and window registers
// depends on pbh_pkg
`timescale 1ns / 1ps
`default_nettype none
module pbh_window #(
  parameter int MAX_WIDTH = 128,
  parameter int WINDOW    = 5
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   rd_en_i,
  input  wire logic [$clog2(MAX_WIDTH)-1:0]           rd_addr_i,
  input  wire logic                                   wr_en_i,
  input  wire logic [$clog2(MAX_WIDTH)-1:0]           wr_addr_i,
  input  wire logic [$clog2(WINDOW-1)-1:0]            wr_slot_i,
  input  wire logic [pbh_pkg::PIX_W-1:0]              wr_pix_i,
  output logic [WINDOW*WINDOW*pbh_pkg::PIX_W-1:0]     win_o
);
  import pbh_pkg::*;

  localparam int LINES  = WINDOW - 1;
  localparam int SLOT_W = $clog2(LINES);
  localparam int MEM_W  = LINES * PIX_W;

  logic [MEM_W-1:0] mem_q [MAX_WIDTH];
  logic [MEM_W-1:0] rd_q;
  logic [MEM_W-1:0] wr_data;
  logic [PIX_W-1:0] col_d [WINDOW];
  logic [PIX_W-1:0] win_q [WINDOW][WINDOW];

  always_comb begin
    logic [SLOT_W:0] s;
    for (int r = 0; r < LINES; r++) begin
      s = (SLOT_W+1)'(wr_slot_i) + (SLOT_W+1)'(r);
      if (s >= (SLOT_W+1)'(LINES)) begin
        s = s - (SLOT_W+1)'(LINES);
      end
      col_d[r] = rd_q[s*PIX_W +: PIX_W];
    end
    col_d[LINES] = wr_pix_i;
    for (int l = 0; l < LINES; l++) begin
      wr_data[l*PIX_W +: PIX_W] = (SLOT_W'(l) == wr_slot_i) ? wr_pix_i
                                                           : rd_q[l*PIX_W +: PIX_W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data;
    end
    if (rd_en_i) begin
      rd_q <= mem_q[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      for (int r = 0; r < WINDOW; r++) begin
        for (int c = 0; c < WINDOW - 1; c++) begin
          win_q[r][c] <= win_q[r][c+1];
        end
        win_q[r][WINDOW-1] <= col_d[r];
      end
    end
  end

  for (genvar r = 0; r < WINDOW; r++) begin : g_row
    for (genvar c = 0; c < WINDOW; c++) begin : g_col
      assign win_o[(r*WINDOW+c)*PIX_W +: PIX_W] = win_q[r][c];
    end
  end

endmodule
`default_nettype wire

/* rtl/core/pbh_filter.sv */
// coefficient store and pipelined projection of the window onto the filters
// depends on pbh_pkg
`timescale 1ns / 1ps
`default_nettype none
module pbh_filter #(
  parameter int WINDOW      = 5,
  parameter int NUM_FILTERS = 4
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic                                   adv_i,
  input  wire logic                                   cwe_i,
  input  wire logic [pbh_pkg::IDX_W-1:0]              cidx_i,
  input  wire logic signed [pbh_pkg::COEF_W-1:0]      cval_i,
  input  wire logic                                   valid_i,
  input  wire pbh_pkg::tag_t                          tag_i,
  input  wire logic [WINDOW*WINDOW*pbh_pkg::PIX_W-1:0] win_i,
  output logic                                        valid_o,
  output pbh_pkg::tag_t                               tag_o,
  output logic [pbh_pkg::CODE_W-1:0]                  code_o
);
  import pbh_pkg::*;

  localparam int TAPS   = WINDOW * WINDOW;
  localparam int NCOEF  = NUM_FILTERS * TAPS;
  localparam int CI_W   = $clog2(NCOEF);
  localparam int LG_W   = $clog2(WINDOW) + 1;
  localparam int PROD_W = COEF_W + PIX_W + 1;
  localparam int ROW_W  = PROD_W + LG_W;
  localparam int TOT_W  = ROW_W + LG_W;
  localparam int KROW_W = COEF_W + LG_W;
  localparam int KS_W   = KROW_W + LG_W;
  localparam int SROW_W = PIX_W + LG_W;
  localparam int S_W    = SROW_W + LG_W;
  localparam int ACC_W  = TOT_W + $clog2(TAPS) + 2;

  logic signed [COEF_W-1:0] coef_q [NCOEF];
  logic [15:0] cidx_ext;

  logic signed [PROD_W-1:0] prod_q [NUM_FILTERS][TAPS];
  logic signed [KROW_W-1:0] krow_q [NUM_FILTERS][WINDOW];
  logic [SROW_W-1:0]        srow_q [WINDOW];
  logic signed [ROW_W-1:0]  rowp_q [NUM_FILTERS][WINDOW];
  logic signed [KS_W-1:0]   ksum_b_q [NUM_FILTERS];
  logic [S_W-1:0]           s_b_q;
  logic signed [TOT_W-1:0]  tot_q [NUM_FILTERS];
  logic signed [KS_W-1:0]   ksum_c_q [NUM_FILTERS];
  logic [S_W-1:0]           s_c_q;
  logic signed [ACC_W-1:0]  ta_q [NUM_FILTERS];
  logic signed [ACC_W-1:0]  tb_q [NUM_FILTERS];
  logic [NUM_FILTERS-1:0]   code_q;
  logic [NUM_FILTERS+CODE_W-1:0] code_ext;

  logic [4:0] vld_q;
  tag_t       tag_q [5];

  assign cidx_ext = 16'(cidx_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NCOEF; i++) begin
        coef_q[i] <= '0;
      end
    end else if (cwe_i && (cidx_ext < 16'(NCOEF))) begin
      coef_q[cidx_ext[CI_W-1:0]] <= cval_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv_i) begin
      vld_q <= {vld_q[3:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      tag_q[0] <= tag_i;
      for (int i = 1; i < 5; i++) begin
        tag_q[i] <= tag_q[i-1];
      end
    end
  end

  // stage a: products, coefficient row sums, pixel row sums
  always_ff @(posedge clk_i) begin
    logic signed [KROW_W-1:0] ka;
    logic [SROW_W-1:0]        sa;
    if (adv_i) begin
      for (int f = 0; f < NUM_FILTERS; f++) begin
        for (int t = 0; t < TAPS; t++) begin
          prod_q[f][t] <= PROD_W'(coef_q[f*TAPS+t]) *
                          PROD_W'($signed({1'b0, win_i[t*PIX_W +: PIX_W]}));
        end
        for (int r = 0; r < WINDOW; r++) begin
          ka = '0;
          for (int c = 0; c < WINDOW; c++) begin
            ka = ka + KROW_W'(coef_q[f*TAPS + r*WINDOW + c]);
          end
          krow_q[f][r] <= ka;
        end
      end
      for (int r = 0; r < WINDOW; r++) begin
        sa = '0;
        for (int c = 0; c < WINDOW; c++) begin
          sa = sa + SROW_W'(win_i[(r*WINDOW+c)*PIX_W +: PIX_W]);
        end
        srow_q[r] <= sa;
      end
    end
  end

  // stage b: product row sums, coefficient sums, window sum
  always_ff @(posedge clk_i) begin
    logic signed [ROW_W-1:0] pb;
    logic signed [KS_W-1:0]  kb;
    logic [S_W-1:0]          sb;
    if (adv_i) begin
      for (int f = 0; f < NUM_FILTERS; f++) begin
        for (int r = 0; r < WINDOW; r++) begin
          pb = '0;
          for (int c = 0; c < WINDOW; c++) begin
            pb = pb + ROW_W'(prod_q[f][r*WINDOW+c]);
          end
          rowp_q[f][r] <= pb;
        end
        kb = '0;
        for (int r = 0; r < WINDOW; r++) begin
          kb = kb + KS_W'(krow_q[f][r]);
        end
        ksum_b_q[f] <= kb;
      end
      sb = '0;
      for (int r = 0; r < WINDOW; r++) begin
        sb = sb + S_W'(srow_q[r]);
      end
      s_b_q <= sb;
    end
  end

  // stage c: total projection per filter
  always_ff @(posedge clk_i) begin
    logic signed [TOT_W-1:0] tc;
    if (adv_i) begin
      for (int f = 0; f < NUM_FILTERS; f++) begin
        tc = '0;
        for (int r = 0; r < WINDOW; r++) begin
          tc = tc + TOT_W'(rowp_q[f][r]);
        end
        tot_q[f]    <= tc;
        ksum_c_q[f] <= ksum_b_q[f];
      end
      s_c_q <= s_b_q;
    end
  end

  // stage d: taps * sum(k x) and window sum * sum(k)
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      for (int f = 0; f < NUM_FILTERS; f++) begin
        ta_q[f] <= ACC_W'(tot_q[f]) * ACC_W'(TAPS);
        tb_q[f] <= ACC_W'(ksum_c_q[f]) * $signed(ACC_W'(s_c_q));
      end
    end
  end

  // stage e: sign test
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      for (int f = 0; f < NUM_FILTERS; f++) begin
        code_q[f] <= (ta_q[f] > tb_q[f]);
      end
    end
  end

  assign code_ext = {{CODE_W{1'b0}}, code_q};
  assign code_o   = code_ext[CODE_W-1:0];
  assign valid_o  = vld_q[4];
  assign tag_o    = tag_q[4];

endmodule
`default_nettype wire
